// ----- rtl/ncd_pkg.sv -----
// Shared types, constants and the scaling function of the nibble codebook dequantizer.
`timescale 1ns / 1ps
package ncd_pkg;
	localparam int BLOCK_VALUES = 32;
	localparam int POS_W = 5;
	localparam logic [0:0] REG_CB_LOW = 1'b0;
	localparam logic [0:0] REG_CB_HIGH = 1'b1;
	localparam logic [31:0] QNAN = 32'h7FC0_0000;
	localparam logic [31:0] INF_BITS = 32'h7F80_0000;

	// One beat of work handed from the block register to the value stage.
	typedef struct packed {
		logic [15:0] scale;
		logic [127:0] codes;
		logic eor;
	} blk_t;

	// Exact fp32 of a half scale times a signed byte.
	function automatic logic [31:0] scale_mul(input logic [15:0] h, input logic [7:0] c);
		logic hs;
		logic [4:0] he;
		logic [9:0] hm;
		logic cs;
		logic [7:0] mag;
		logic [10:0] sig;
		logic [18:0] p;
		logic [4:0] t;
		logic [7:0] ex;
		logic [22:0] frac;
		logic [41:0] sh;
		hs = h[15];
		he = h[14:10];
		hm = h[9:0];
		cs = c[7];
		mag = c[7] ? 8'(-c) : c;
		sig = (he == 5'd0) ? {1'b0, hm} : {1'b1, hm};
		p = 19'(sig * mag);
		t = 5'd0;
		for (int i = 0; i < 19; i++) begin
			if (p[i]) t = 5'(i);
		end
		// Exponent: t + (he or 1) - 25 + 127.
		ex = 8'(t) + ((he == 5'd0) ? 8'd1 : 8'(he)) + 8'd102;
		sh = 42'(p) << (5'd23 - t);
		frac = sh[22:0];
		if (he == 5'd31) begin
			if (hm != 10'd0) scale_mul = {hs, 31'h7FC0_0000 | {8'd0, hm, 13'd0}};
			else if (mag == 8'd0) scale_mul = QNAN;
			else scale_mul = {hs ^ cs, INF_BITS[30:0]};
		end else if (p == 19'd0) begin
			scale_mul = {hs ^ cs, 31'd0};
		end else begin
			scale_mul = {hs ^ cs, ex, frac};
		end
	endfunction
endpackage

// ----- rtl/ncd_value_stage.sv -----
// Walks one held block over 32 positions and registers one fp32 value per beat.
`timescale 1ns / 1ps
module ncd_value_stage (
	input logic clk,
	input logic arst_n,
	input logic blk_valid,
	input ncd_pkg::blk_t blk,
	input logic [127:0] codebook,
	output logic blk_take,
	output logic valid,
	input logic stall,
	output logic [31:0] value_bits,
	output logic [4:0] position,
	output logic last_of_block,
	output logic row_done
);
	import ncd_pkg::*;
	logic [POS_W-1:0] pos_q;
	logic [7:0] byte_sel;
	logic [3:0] nib;
	logic [7:0] entry;
	logic adv;

	assign adv = blk_valid && (!valid || !stall);
	assign blk_take = adv && (pos_q == POS_W'(BLOCK_VALUES - 1));
	assign byte_sel = blk.codes[{pos_q[3:0], 3'd0} +: 8];
	assign nib = pos_q[4] ? byte_sel[7:4] : byte_sel[3:0];
	assign entry = codebook[{nib, 3'd0} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			valid <= 1'b0;
		end else begin
			if (adv) pos_q <= pos_q + 1'b1;
			if (adv) valid <= 1'b1;
			else if (!stall) valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_bits <= scale_mul(blk.scale, entry);
			position <= pos_q;
			last_of_block <= (pos_q == POS_W'(BLOCK_VALUES - 1));
			row_done <= (pos_q == POS_W'(BLOCK_VALUES - 1)) && blk.eor;
		end
	end
endmodule

// ----- rtl/nibble_codebook_dequantizer.sv -----
// Top level of the nibble codebook dequantizer.
// A beat is registered in the input register, its first value then in the
// value stage's output. One value per cycle while out_stall is low; the
// next block is taken as the current block's last value advances.
// Reset clears control state and both codebook registers to zero.
`timescale 1ns / 1ps
module nibble_codebook_dequantizer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [15:0] scale_bits,
	input logic [63:0] codes_first,
	input logic [63:0] codes_second,
	input logic end_of_row,
	output logic out_valid,
	input logic out_stall,
	output logic [31:0] value_bits,
	output logic [4:0] position,
	output logic last_of_block,
	output logic row_done,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [63:0] cfg_data
);
	import ncd_pkg::*;
	logic [63:0] cb_low_q, cb_high_q;
	blk_t blk_s1;
	logic blk_valid_s1;
	logic blk_take;

	assign cfg_ready = 1'b1;
	assign in_stall = blk_valid_s1 && !blk_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_low_q <= '0;
			cb_high_q <= '0;
			blk_valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == REG_CB_LOW) cb_low_q <= cfg_data;
			if (cfg_valid && cfg_index == REG_CB_HIGH) cb_high_q <= cfg_data;
			if (in_valid && !in_stall) blk_valid_s1 <= 1'b1;
			else if (blk_take) blk_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) blk_s1 <= '{scale_bits, {codes_second, codes_first}, end_of_row};
	end

	ncd_value_stage u_val (
		.clk(clk), .arst_n(arst_n), .blk_valid(blk_valid_s1), .blk(blk_s1),
		.codebook({cb_high_q, cb_low_q}), .blk_take(blk_take), .valid(out_valid),
		.stall(out_stall), .value_bits(value_bits), .position(position),
		.last_of_block(last_of_block), .row_done(row_done)
	);

`ifndef ASSERT_OFF
	a_rowdone_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_done |-> last_of_block) else $error("row_done off last value");
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_block |-> position == 5'd31) else $error("last not at 31");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		blk_take |-> blk_valid_s1) else $error("take without block");
`endif
endmodule

// ----- sim/ncd_checker.sv -----
// Checker that predicts and compares the dequantized values of the codebook dequantizer.
`timescale 1ns / 1ps
module ncd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [15:0] scale_bits,
	input logic [63:0] codes_first,
	input logic [63:0] codes_second,
	input logic end_of_row,
	input logic out_valid,
	input logic out_stall,
	input logic [31:0] value_bits,
	input logic [4:0] position,
	input logic last_of_block,
	input logic row_done,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [63:0] cfg_data,
	output int fail_count,
	output int pending
);
	import ncd_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic [4:0] pos;
		logic last;
		logic done;
	} dq_value_t;

	logic [63:0] cb_low, cb_high;
	dq_value_t expected_values[$];

	assign pending = expected_values.size();

	// Exact product of a half scale and a signed codebook entry as fp32 bits.
	function automatic logic [31:0] fp32_product(logic [15:0] h, logic signed [7:0] c);
		logic sgn;
		logic [7:0] mag;
		logic [10:0] sig;
		logic [18:0] prod;
		int msb;
		int ex;
		logic [41:0] wide;
		mag = (c < 0) ? 8'(-c) : 8'(c);
		sgn = h[15] ^ c[7];
		if (h[14:10] == 5'h1f) begin
			if (h[9:0] != 0) return {h[15], 8'hff, 1'b1, h[8:0], 13'd0};
			if (mag == 0) return 32'h7fc0_0000;
			return {sgn, 31'h7f80_0000};
		end
		if (h[14:10] == 0) begin
			sig = {1'b0, h[9:0]};
			ex = -24;
		end else begin
			sig = {1'b1, h[9:0]};
			ex = int'(h[14:10]) - 25;
		end
		prod = sig * mag;
		if (prod == 0) return {sgn, 31'd0};
		msb = 0;
		for (int i = 0; i < 19; i++) if (prod[i]) msb = i;
		wide = 42'(prod) << (23 - msb);
		return {sgn, 8'(msb + ex + 127), wide[22:0]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] codes;
		logic [3:0] nib;
		logic [63:0] word;
		dq_value_t v, want;
		if (!arst_n) begin
			cb_low <= '0;
			cb_high <= '0;
			fail_count <= 0;
			expected_values.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_CB_LOW) cb_low <= cfg_data;
				else cb_high <= cfg_data;
			end
			if (out_valid && !out_stall) begin
				v = {value_bits, position, last_of_block, row_done};
				if (expected_values.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10) $display("unexpected value beat %h", v);
				end else begin
					want = expected_values.pop_front();
					if (v !== want) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display({"mismatch: exp val %h pos %0d last %b done %b,",
								" got val %h pos %0d last %b done %b"},
								want.value, want.pos, want.last, want.done,
								value_bits, position, last_of_block, row_done);
					end
				end
			end
			if (in_valid && !in_stall) begin
				codes = {codes_second, codes_first};
				for (int p = 0; p < BLOCK_VALUES; p++) begin
					nib = (p < 16) ? codes[8*(p%16) +: 4] : codes[8*(p%16)+4 +: 4];
					word = nib[3] ? cb_high : cb_low;
					want.value = fp32_product(scale_bits, word[8*nib[2:0] +: 8]);
					want.pos = 5'(p);
					want.last = (p == 31);
					want.done = (p == 31) && end_of_row;
					expected_values.push_back(want);
				end
			end
		end
	end
endmodule

// ----- sim/tb.sv -----
// Stimulus and verdict for the nibble codebook dequantizer testbench.
`timescale 1ns / 1ps
module tb;
	import ncd_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [15:0] scale_bits = 0;
	logic [63:0] codes_first = 0, codes_second = 0;
	logic end_of_row = 0;
	logic [31:0] value_bits;
	logic [4:0] position;
	logic last_of_block, row_done;
	logic cfg_valid = 0, cfg_ready;
	logic [0:0] cfg_index = REG_CB_LOW;
	logic [63:0] cfg_data = 0;
	int fail_count, pending;
	int send_idle = 0, recv_idle = 0;
	bit hold_recv = 0;
	int quiet = 0;

	always #4 clk = ~clk;

	nibble_codebook_dequantizer DUT (.*);
	ncd_checker chk (.*);

	// Receiver stall, with a long hold-off window on request.
	always @(posedge clk) out_stall <= hold_recv || ($urandom_range(99) < recv_idle);

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Valid stays high between back-to-back beats; it drops only on an idle cycle.
	task automatic send_block(logic [15:0] s, logic [63:0] a, logic [63:0] b, logic e);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		scale_bits <= s;
		codes_first <= a;
		codes_second <= b;
		end_of_row <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_codebook(logic [0:0] idx, logic [63:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_scale();
		case ($urandom_range(9))
			0: return {1'($urandom), 5'h1f, 10'($urandom)};
			1: return {1'($urandom), 5'h00, 10'($urandom)};
			2: return {1'($urandom), 5'h1f, 10'd0};
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_blocks(int n);
		for (int i = 0; i < n; i++)
			send_block(rand_scale(), {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
	endtask

	initial begin
		logic [15:0] dir_scales[12];
		dir_scales = '{16'h0000, 16'h8000, 16'h3c00, 16'hbc00, 16'h7bff, 16'hfbff,
			16'h0001, 16'h83ff, 16'h7c00, 16'hfc00, 16'h7e01, 16'hfd55};
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Default codebook of zeros first.
		send_block(16'h3c00, 64'h0123456789abcdef, 64'hfedcba9876543210, 1);
		send_block(16'h7c00, '1, '1, 0);
		wait_drain();
		// Codebook with extremes: -128, 127, 0, -1.
		write_codebook(REG_CB_LOW, 64'h80_7f_00_ff_01_81_7e_10);
		write_codebook(REG_CB_HIGH, 64'hf0_0f_c0_40_20_e0_08_f8);
		foreach (dir_scales[k])
			send_block(dir_scales[k], 64'h0123456789abcdef, 64'hfedcba9876543210, 1'(k));
		send_block(16'h4000, '0, '0, 0);
		send_block(16'h4000, '1, '1, 1);
		wait_drain();
		// Three idling phases, each with its own codebook, random in the first two.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 33 : (ph == 1) ? 52 : 0;
			recv_idle = (ph == 0) ? 52 : (ph == 1) ? 33 : 0;
			write_codebook(REG_CB_LOW, (ph == 2) ? 64'h8080808080808080 : {$urandom, $urandom});
			write_codebook(REG_CB_HIGH, (ph == 2) ? 64'h7f7f7f7f7f7f7f7f : {$urandom, $urandom});
			random_blocks(120);
			if (ph == 1) begin
				// Receiver holds off while blocks keep coming.
				fork
					begin
						hold_recv <= 1;
						repeat (300) @(posedge clk);
						hold_recv <= 0;
					end
					random_blocks(6);
				join
			end
			wait_drain();
		end
		write_codebook(REG_CB_LOW, {$urandom, $urandom});
		write_codebook(REG_CB_HIGH, {$urandom, $urandom});
		random_blocks(30);
		wait_drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/ncd_pkg.sv
rtl/ncd_value_stage.sv
rtl/nibble_codebook_dequantizer.sv
sim/ncd_checker.sv
sim/tb.sv
